### hw/rtl/lcu_pkg.sv
// Shared widths and codes for the line clipper.
package lcu_pkg;
  localparam int IN_W  = 16;
  localparam int D_W   = 17;
  localparam int OUT_W = 18;
  localparam int NLANE = 4;
  localparam int LANE_TOP    = 0;
  localparam int LANE_BOTTOM = 1;
  localparam int LANE_LEFT   = 2;
  localparam int LANE_RIGHT  = 3;
  localparam logic SIDES_TB = 1'b0;
  localparam logic SIDES_LR = 1'b1;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
endpackage

### hw/rtl/line_clip_to_unit_square.sv
// Top level of the pipelined line clipper.
//
// An input word is taken at a rising edge where start is high and busy is
// low. Busy is always low, so one line may be given in every cycle.
// Each line yields one result word, shown on the out_ ports for exactly one
// cycle with out_valid high, in the order the lines were taken.
// Each of the four parallel restoring dividers yields QW quotient bits,
// where QW = max(FRAC_BITS, 16) + 3, and retires one quotient bit per
// stage, so the dividers set most of the pipeline depth.
// Throughput is one line per cycle.
// The multiply, the magnitude with the overflow test, each divider stage,
// the final add and the select with saturation each occupy their own register stage.
// Reset clears every valid bit in the pipeline; lines in flight are dropped.
// The receiver cannot stall, so nothing ever holds the pipeline.
module line_clip_to_unit_square
  import lcu_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_point_a_x,
  input  logic signed [IN_W-1:0]  in_point_a_y,
  input  logic signed [IN_W-1:0]  in_point_b_x,
  input  logic signed [IN_W-1:0]  in_point_b_y,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_end_one_x,
  output logic signed [OUT_W-1:0] out_end_one_y,
  output logic signed [OUT_W-1:0] out_end_two_x,
  output logic signed [OUT_W-1:0] out_end_two_y,
  output logic                    out_used_sides,
  output logic                    out_degenerate
);
  localparam int MW = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int NW = MW + 3;
  localparam int PW = NW + D_W;
  localparam int QW = MW + 3;
  localparam int DW = PW + QW;
  localparam int SW = QW + 2;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint EPS = ONE / 10000;
  localparam logic signed [NW-1:0] ONE_N = NW'(ONE);
  localparam logic signed [SW-1:0] ONE_S = SW'(ONE);

  typedef struct packed {
    logic                   valid;
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic                   degen;
    logic                   tb_np;
    logic                   lr_np;
  } side_t;

  typedef struct packed {
    logic [DW-1:0]  rem;
    logic [D_W-1:0] den;
    logic [QW-1:0]  q;
    logic           neg;
    logic           ovf;
  } lane_t;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SW'(OUT_MAX)) r = OUT_MAX;
    else if (v < SW'(OUT_MIN)) r = OUT_MIN;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic in_unit(input logic signed [SW-1:0] v, input logic ovf);
    return !ovf && (v >= -ONE_S) && (v <= ONE_S);
  endfunction

  function automatic logic non_par(input logic signed [D_W-1:0] d);
    logic [D_W:0] m;
    m = d[D_W-1] ? -{d[D_W-1], d} : {d[D_W-1], d};
    return (64'({m, 1'b0}) > 64'(EPS));
  endfunction

  assign busy = 1'b0;

  // Stage 1: differences, numerators and edge flags.
  side_t                  s1_side_r;
  logic signed [D_W-1:0]  s1_dx_r, s1_dy_r;
  logic signed [NW-1:0]   s1_num_r [NLANE];
  logic signed [D_W-1:0]  dx_nxt, dy_nxt;

  assign dx_nxt = D_W'(in_point_b_x) - D_W'(in_point_a_x);
  assign dy_nxt = D_W'(in_point_b_y) - D_W'(in_point_a_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else begin
      s1_side_r.valid <= start;
    end
    s1_side_r.ax    <= in_point_a_x;
    s1_side_r.ay    <= in_point_a_y;
    s1_side_r.degen <= (dx_nxt == '0) && (dy_nxt == '0);
    s1_side_r.tb_np <= non_par(dy_nxt);
    s1_side_r.lr_np <= non_par(dx_nxt);
    s1_dx_r <= dx_nxt;
    s1_dy_r <= dy_nxt;
    s1_num_r[LANE_TOP]    <= ONE_N - NW'(in_point_a_y);
    s1_num_r[LANE_BOTTOM] <= -ONE_N - NW'(in_point_a_y);
    s1_num_r[LANE_LEFT]   <= -ONE_N - NW'(in_point_a_x);
    s1_num_r[LANE_RIGHT]  <= ONE_N - NW'(in_point_a_x);
  end

  // Stage 2: products.
  side_t                 s2_side_r;
  logic signed [PW-1:0]  s2_p_r   [NLANE];
  logic signed [D_W-1:0] s2_den_r [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.valid <= 1'b0;
    end else begin
      s2_side_r.valid <= s1_side_r.valid;
    end
    s2_side_r.ax    <= s1_side_r.ax;
    s2_side_r.ay    <= s1_side_r.ay;
    s2_side_r.degen <= s1_side_r.degen;
    s2_side_r.tb_np <= s1_side_r.tb_np;
    s2_side_r.lr_np <= s1_side_r.lr_np;
    s2_p_r[LANE_TOP]    <= PW'(s1_num_r[LANE_TOP]) * PW'(s1_dx_r);
    s2_p_r[LANE_BOTTOM] <= PW'(s1_num_r[LANE_BOTTOM]) * PW'(s1_dx_r);
    s2_p_r[LANE_LEFT]   <= PW'(s1_num_r[LANE_LEFT]) * PW'(s1_dy_r);
    s2_p_r[LANE_RIGHT]  <= PW'(s1_num_r[LANE_RIGHT]) * PW'(s1_dy_r);
    s2_den_r[LANE_TOP]    <= s1_dy_r;
    s2_den_r[LANE_BOTTOM] <= s1_dy_r;
    s2_den_r[LANE_LEFT]   <= s1_dx_r;
    s2_den_r[LANE_RIGHT]  <= s1_dx_r;
  end

  // Stage 3: magnitudes and quotient overflow, then the divider stages.
  side_t ds_r [QW+1];
  lane_t dv_r [QW+1][NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r[0].valid <= 1'b0;
    end else begin
      ds_r[0].valid <= s2_side_r.valid;
    end
    ds_r[0].ax    <= s2_side_r.ax;
    ds_r[0].ay    <= s2_side_r.ay;
    ds_r[0].degen <= s2_side_r.degen;
    ds_r[0].tb_np <= s2_side_r.tb_np;
    ds_r[0].lr_np <= s2_side_r.lr_np;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane_in
    logic [PW-1:0]  pmag;
    logic [D_W-1:0] dmag;
    assign pmag = s2_p_r[l][PW-1] ? PW'(-s2_p_r[l]) : PW'(s2_p_r[l]);
    assign dmag = s2_den_r[l][D_W-1] ? D_W'(-s2_den_r[l]) : D_W'(s2_den_r[l]);
    always_ff @(posedge clk) begin
      dv_r[0][l].rem <= DW'(pmag);
      dv_r[0][l].den <= dmag;
      dv_r[0][l].q   <= '0;
      dv_r[0][l].neg <= s2_p_r[l][PW-1] ^ s2_den_r[l][D_W-1];
      dv_r[0][l].ovf <= DW'(pmag) >= (DW'(dmag) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ds_r[k+1].valid <= 1'b0;
      end else begin
        ds_r[k+1].valid <= ds_r[k].valid;
      end
      ds_r[k+1].ax    <= ds_r[k].ax;
      ds_r[k+1].ay    <= ds_r[k].ay;
      ds_r[k+1].degen <= ds_r[k].degen;
      ds_r[k+1].tb_np <= ds_r[k].tb_np;
      ds_r[k+1].lr_np <= ds_r[k].lr_np;
    end
    for (genvar l = 0; l < NLANE; l++) begin : g_bit
      logic [DW:0] trial;
      assign trial = {1'b0, dv_r[k][l].rem} - ({1'b0, DW'(dv_r[k][l].den)} << (QW-1-k));
      always_ff @(posedge clk) begin
        dv_r[k+1][l].den <= dv_r[k][l].den;
        dv_r[k+1][l].neg <= dv_r[k][l].neg;
        dv_r[k+1][l].ovf <= dv_r[k][l].ovf;
        dv_r[k+1][l].rem <= trial[DW] ? dv_r[k][l].rem : trial[DW-1:0];
        dv_r[k+1][l].q   <= dv_r[k][l].q | (QW'(!trial[DW]) << (QW-1-k));
      end
    end
  end

  // Sum stage: signed quotient plus base.
  side_t                sm_side_r;
  logic signed [SW-1:0] sm_c_r   [NLANE];
  logic                 sm_ovf_r [NLANE];
  logic                 sm_neg_r [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_side_r.valid <= 1'b0;
    end else begin
      sm_side_r.valid <= ds_r[QW].valid;
    end
    sm_side_r.ax    <= ds_r[QW].ax;
    sm_side_r.ay    <= ds_r[QW].ay;
    sm_side_r.degen <= ds_r[QW].degen;
    sm_side_r.tb_np <= ds_r[QW].tb_np;
    sm_side_r.lr_np <= ds_r[QW].lr_np;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_sum
    logic signed [SW-1:0] qs, base;
    assign qs   = dv_r[QW][l].neg ? -SW'(dv_r[QW][l].q) : SW'(dv_r[QW][l].q);
    assign base = (l < LANE_LEFT) ? SW'(ds_r[QW].ax) : SW'(ds_r[QW].ay);
    always_ff @(posedge clk) begin
      sm_c_r[l]   <= base + qs;
      sm_ovf_r[l] <= dv_r[QW][l].ovf;
      sm_neg_r[l] <= dv_r[QW][l].neg;
    end
  end

  // Output stage: edge choice and saturation.
  logic signed [OUT_W-1:0] e_nxt [NLANE];
  logic                    tb_ok;

  for (genvar l = 0; l < NLANE; l++) begin : g_sat
    assign e_nxt[l] = sm_ovf_r[l] ? (sm_neg_r[l] ? OUT_MIN : OUT_MAX) : sat(sm_c_r[l]);
  end

  assign tb_ok = sm_side_r.tb_np && in_unit(sm_c_r[LANE_TOP], sm_ovf_r[LANE_TOP]) &&
                 in_unit(sm_c_r[LANE_BOTTOM], sm_ovf_r[LANE_BOTTOM]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sm_side_r.valid;
    end
    out_degenerate <= sm_side_r.degen;
    if (sm_side_r.degen) begin
      out_used_sides <= SIDES_TB;
      out_end_one_x  <= '0;
      out_end_one_y  <= '0;
      out_end_two_x  <= '0;
      out_end_two_y  <= '0;
    end else if (tb_ok) begin
      out_used_sides <= SIDES_TB;
      out_end_one_x  <= e_nxt[LANE_TOP];
      out_end_one_y  <= sat(ONE_S);
      out_end_two_x  <= e_nxt[LANE_BOTTOM];
      out_end_two_y  <= sat(-ONE_S);
    end else if (sm_side_r.lr_np) begin
      out_used_sides <= SIDES_LR;
      out_end_one_x  <= sat(-ONE_S);
      out_end_one_y  <= e_nxt[LANE_LEFT];
      out_end_two_x  <= sat(ONE_S);
      out_end_two_y  <= e_nxt[LANE_RIGHT];
    end else begin
      out_used_sides <= SIDES_LR;
      out_end_one_x  <= OUT_MAX;
      out_end_one_y  <= OUT_MAX;
      out_end_two_x  <= OUT_MAX;
      out_end_two_y  <= OUT_MAX;
    end
  end
endmodule

### hw/rtl/lcu_checker.sv
// Port-level checks for the line clipper, bound to its top level.
module lcu_checker
  import lcu_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_end_one_x,
  input logic signed [OUT_W-1:0] out_end_one_y,
  input logic signed [OUT_W-1:0] out_end_two_x,
  input logic signed [OUT_W-1:0] out_end_two_y,
  input logic                    out_used_sides,
  input logic                    out_degenerate
);
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_used_sides == SIDES_TB &&
      out_end_one_x == '0 && out_end_one_y == '0 &&
      out_end_two_x == '0 && out_end_two_y == '0)
    else $error("degenerate word carries nonzero ends");

  a_tb_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate && out_used_sides == SIDES_TB |->
      !out_end_one_y[OUT_W-1] && out_end_two_y[OUT_W-1])
    else $error("top and bottom crossings on wrong rows");

  a_lr_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate && out_used_sides == SIDES_LR |->
      (out_end_one_x[OUT_W-1] && !out_end_two_x[OUT_W-1]) ||
      (out_end_one_x == OUT_MAX && out_end_two_x == OUT_MAX))
    else $error("side crossings on wrong columns");
endmodule

bind line_clip_to_unit_square lcu_checker u_lcu_checker (.*);
